/* hdl/page_table_walk_translate_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the page table walker
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_WALK_TRANSLATE_ASSERT_SVH
`define PAGE_TABLE_WALK_TRANSLATE_ASSERT_SVH

// same-cycle implication
`define PTWT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ptwt_pkg.sv */
// ----------------------------------------------------------------------------
// ptwt_pkg
// Types and constants shared by the page table walker modules.
// ----------------------------------------------------------------------------
package ptwt_pkg;

    localparam int VA_W        = 48;
    localparam int PA_W        = 52;
    localparam int ENTRY_W     = 64;
    localparam int INDEX_BITS  = 9;
    localparam int PAGE_SHIFT  = 12;

    localparam int DEF_VA_BITS     = 48;
    localparam int DEF_PA_BITS     = 52;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_SIZE_BIT    = 7;

    localparam logic       KIND_REQ  = 1'b0;
    localparam logic       KIND_DONE = 1'b1;

    localparam logic       MODE_XLATE = 1'b0;
    localparam logic       MODE_RESP  = 1'b1;

    localparam logic [1:0] PSIZE_4K = 2'd0;
    localparam logic [1:0] PSIZE_2M = 2'd1;
    localparam logic [1:0] PSIZE_1G = 2'd2;

    localparam logic [1:0] LEVEL_PT   = 2'd0;
    localparam logic [1:0] LEVEL_PD   = 2'd1;
    localparam logic [1:0] LEVEL_PDPT = 2'd2;
    localparam logic [1:0] LEVEL_TOP  = 2'd3;

    // classified item; word holds the masked vaddr or the table entry
    typedef struct packed {
        logic               is_xlate;
        logic [ENTRY_W-1:0] word;
    } t_ptw_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_ptw_q_stat;

endpackage

/* hdl/ptwt_front.sv */
// ----------------------------------------------------------------------------
// ptwt_front
// Input side: takes items, tags translate vs response, masks the vaddr.
// ----------------------------------------------------------------------------
module ptwt_front
    import ptwt_pkg::*;
#(
    parameter int VA_BITS = DEF_VA_BITS
) (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic [VA_W-1:0]   i_virt_addr,
    input  logic [ENTRY_W-1:0] i_read_data,
    input  t_ptw_q_stat       i_q_stat,
    output logic              o_push,
    output t_ptw_item         o_item
);

    localparam int VA_EFF = (VA_BITS < VA_W) ? VA_BITS : VA_W;
    localparam logic [VA_W-1:0] VA_MASK = {VA_W{1'b1}} >> (VA_W - VA_EFF);

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_item.is_xlate = (i_mode == MODE_XLATE);
        if (i_mode == MODE_XLATE) begin
            o_item.word = {{(ENTRY_W-VA_W){1'b0}}, i_virt_addr & VA_MASK};
        end else begin
            o_item.word = i_read_data;
        end
    end

endmodule

/* hdl/ptwt_queue.sv */
// ----------------------------------------------------------------------------
// ptwt_queue
// Small FIFO between the front and the walk engine.
// ----------------------------------------------------------------------------
module ptwt_queue
    import ptwt_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_ptw_item   i_item,
    input  logic        i_pop,
    output t_ptw_item   o_item,
    output t_ptw_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_ptw_item          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* hdl/ptwt_back.sv */
// ----------------------------------------------------------------------------
// ptwt_back
// Walk engine: holds the walk state, checks entries, registers results.
// ----------------------------------------------------------------------------
module ptwt_back
    import ptwt_pkg::*;
#(
    parameter int PA_BITS = DEF_PA_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PA_W-1:0]   i_root_base,
    input  t_ptw_q_stat       i_q_stat,
    input  t_ptw_item         i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_kind,
    output logic [PA_W-1:0]   o_read_addr,
    output logic [PA_W-1:0]   o_phys_addr,
    output logic              o_fault,
    output logic [1:0]        o_pg_size
);

    localparam logic [PA_W-1:0] PA_MASK = {PA_W{1'b1}} >> (PA_W - PA_BITS);

    logic              r_busy;
    logic [1:0]        r_level;
    logic [VA_W-1:0]   r_vaddr;

    logic              r_out_valid;
    logic              r_kind;
    logic [PA_W-1:0]   r_read_addr;
    logic [PA_W-1:0]   r_phys_addr;
    logic              r_fault;
    logic [1:0]        r_pg_size;

    logic              n_busy;
    logic [1:0]        n_level;
    logic [VA_W-1:0]   n_vaddr;
    logic              n_has_result;
    logic              n_kind;
    logic [PA_W-1:0]   n_read_addr;
    logic [PA_W-1:0]   n_phys_addr;
    logic              n_fault;
    logic [1:0]        n_pg_size;

    logic [PA_W-1:0]   entry_pa;
    logic              present;
    logic              size_bit;

    function automatic logic [PA_W-1:0] entry_addr(
        input logic [PA_W-1:0] table_pa,
        input logic [VA_W-1:0] va,
        input logic [1:0]      lvl
    );
        logic [INDEX_BITS-1:0] idx;
        case (lvl)
            LEVEL_TOP:  idx = va[PAGE_SHIFT + 3*INDEX_BITS +: INDEX_BITS];
            LEVEL_PDPT: idx = va[PAGE_SHIFT + 2*INDEX_BITS +: INDEX_BITS];
            LEVEL_PD:   idx = va[PAGE_SHIFT + INDEX_BITS +: INDEX_BITS];
            default:    idx = va[PAGE_SHIFT +: INDEX_BITS];
        endcase
        return ({table_pa[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} & PA_MASK)
             | {{(PA_W-INDEX_BITS-3){1'b0}}, idx, 3'b000};
    endfunction

    assign o_pop    = !i_q_stat.empty && (!r_out_valid || i_out_ready);
    assign entry_pa = i_item.word[PA_W-1:0];
    assign present  = i_item.word[ENTRY_PRESENT_BIT];
    assign size_bit = i_item.word[ENTRY_SIZE_BIT];

    always_comb begin
        n_busy       = r_busy;
        n_level      = r_level;
        n_vaddr      = r_vaddr;
        n_has_result = 1'b0;
        n_kind       = KIND_REQ;
        n_read_addr  = '0;
        n_phys_addr  = '0;
        n_fault      = 1'b0;
        n_pg_size    = PSIZE_4K;

        if (i_item.is_xlate) begin
            n_vaddr      = i_item.word[VA_W-1:0];
            n_level      = LEVEL_TOP;
            n_busy       = 1'b1;
            n_has_result = 1'b1;
            n_read_addr  = entry_addr(i_root_base, i_item.word[VA_W-1:0], LEVEL_TOP);
        end else if (r_busy) begin
            n_has_result = 1'b1;
            if (!present) begin
                n_busy  = 1'b0;
                n_level = LEVEL_PT;
                n_kind  = KIND_DONE;
                n_fault = 1'b1;
            end else if (r_level == LEVEL_PDPT && size_bit) begin
                n_busy      = 1'b0;
                n_level     = LEVEL_PT;
                n_kind      = KIND_DONE;
                n_pg_size   = PSIZE_1G;
                n_phys_addr = {entry_pa[PA_W-1:30], r_vaddr[29:0]} & PA_MASK;
            end else if (r_level == LEVEL_PD && size_bit) begin
                n_busy      = 1'b0;
                n_level     = LEVEL_PT;
                n_kind      = KIND_DONE;
                n_pg_size   = PSIZE_2M;
                n_phys_addr = {entry_pa[PA_W-1:21], r_vaddr[20:0]} & PA_MASK;
            end else if (r_level == LEVEL_PT) begin
                n_busy      = 1'b0;
                n_kind      = KIND_DONE;
                n_pg_size   = PSIZE_4K;
                n_phys_addr = {entry_pa[PA_W-1:PAGE_SHIFT], r_vaddr[PAGE_SHIFT-1:0]}
                            & PA_MASK;
            end else begin
                // table entry: descend one level
                n_level     = r_level - 2'd1;
                n_read_addr = entry_addr(entry_pa, r_vaddr, r_level - 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_level     <= LEVEL_PT;
            r_vaddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy      <= n_busy;
                r_level     <= n_level;
                r_vaddr     <= n_vaddr;
                r_out_valid <= n_has_result;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_has_result) begin
            r_kind      <= n_kind;
            r_read_addr <= n_read_addr;
            r_phys_addr <= n_phys_addr;
            r_fault     <= n_fault;
            r_pg_size   <= n_pg_size;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_read_addr = r_read_addr;
    assign o_phys_addr = r_phys_addr;
    assign o_fault     = r_fault;
    assign o_pg_size   = r_pg_size;

endmodule

/* hdl/page_table_walk_translate.sv */
// ----------------------------------------------------------------------------
// page_table_walk_translate
// Four-level page table walker with 4K, 2M and 1G pages.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_data (root table base)
//  in       | i_in_valid / o_in_ready   | i_mode, i_virt_addr, i_read_data
//  out      | o_out_valid / i_out_ready | o_kind, o_read_addr, o_phys_addr,
//           |                           | o_fault, o_pg_size
//
//  One item per cycle sustained while the output is not stalled; a result
//  passes through the queue write, then the walk engine's output register.
//  Synchronous active-low reset clears the walk state, queue and output valid.
//  A two-entry queue lets input keep flowing for two items while the output
//  stalls; the engine stops popping while its output register is held.
//  o_cfg_ready is always high.
// ----------------------------------------------------------------------------
module page_table_walk_translate
    import ptwt_pkg::*;
#(
    parameter int VA_BITS     = DEF_VA_BITS,
    parameter int PA_BITS     = DEF_PA_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [PA_W-1:0]    i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [VA_W-1:0]    i_virt_addr,
    input  logic [ENTRY_W-1:0] i_read_data,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic [PA_W-1:0]    o_read_addr,
    output logic [PA_W-1:0]    o_phys_addr,
    output logic               o_fault,
    output logic [1:0]         o_pg_size
);

    `include "page_table_walk_translate_assert.svh"

    logic [PA_W-1:0] r_root_base;
    t_ptw_q_stat     q_stat;
    t_ptw_item       push_item;
    t_ptw_item       head_item;
    logic            push;
    logic            pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_base <= '0;
        end else if (i_cfg_valid) begin
            r_root_base <= i_cfg_data;
        end
    end

    ptwt_front #(
        .VA_BITS (VA_BITS)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_virt_addr (i_virt_addr),
        .i_read_data (i_read_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_item      (push_item)
    );

    ptwt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    ptwt_back #(
        .PA_BITS (PA_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_root_base (r_root_base),
        .i_q_stat    (q_stat),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_read_addr (o_read_addr),
        .o_phys_addr (o_phys_addr),
        .o_fault     (o_fault),
        .o_pg_size   (o_pg_size)
    );

    `PTWT_ASSERT_NOW(a_q_stat_sane, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
    `PTWT_ASSERT_NOW(a_fault_clean, o_out_valid && o_fault, (o_kind == KIND_DONE) && (o_phys_addr == '0) && (o_pg_size == PSIZE_4K), "fault result carries data")
    `PTWT_ASSERT_NOW(a_req_clean, o_out_valid && (o_kind == KIND_REQ), !o_fault && (o_phys_addr == '0) && (o_pg_size == PSIZE_4K), "request carries done fields")
    `PTWT_ASSERT_NEXT(a_push_lands, push && !pop, !q_stat.empty, "pushed item lost")

endmodule
